[hdl/rcpw_pkg.sv]
// Shared constants and types for the RC pulse-width to stick value decoder.
package rcpw_pkg;

  localparam int unsigned CHANNELS  = 4;
  localparam int unsigned CHAN_W    = 2;
  localparam int unsigned STAMP_W   = 32;
  localparam int unsigned CAL_W     = 24;
  localparam int unsigned CAL_COUNT = 4;
  localparam int unsigned DEAD_W    = 7;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned STICK_W   = 12;

  localparam logic [CAL_W-1:0]  CAL_RESET  = 24'd8193000;
  localparam logic [DEAD_W-1:0] DEAD_RESET = 7'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_CAL0      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_DEAD_BAND = 3'd4;

  localparam logic [STAMP_W-1:0] WIDTH_LOW  = 32'd700;
  localparam logic [STAMP_W-1:0] WIDTH_HIGH = 32'd2100;

  // Calibration halves and the mapping constants.
  localparam int unsigned HALF_W   = 12;
  localparam int unsigned NUM_W    = 20;
  localparam int unsigned DEN_W    = 12;
  localparam int unsigned DIV_CNT_W = $clog2(NUM_W);
  localparam logic [NUM_W-1:0] OUT_SPAN   = 20'd200;
  localparam logic [21:0]      OUT_OFFSET = 22'd100;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } rcpw_div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quo;
  } rcpw_div_rsp_t;

endpackage

[hdl/rcpw_div.sv]
// Bit-serial restoring divider: one quotient bit per cycle.
module rcpw_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rcpw_pkg::rcpw_div_req_t req_i,
  output rcpw_pkg::rcpw_div_rsp_t rsp_o
);

  logic [rcpw_pkg::NUM_W-1:0]     quo_q, quo_d;
  logic [rcpw_pkg::DEN_W-1:0]     rem_q, rem_d;
  logic [rcpw_pkg::DEN_W-1:0]     den_q, den_d;
  logic [rcpw_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [rcpw_pkg::DEN_W+1:0]     trial;
  logic                           ge;

  assign trial = {1'b0, rem_q, quo_q[rcpw_pkg::NUM_W-1]} - {2'b00, den_q};
  assign ge    = ~trial[rcpw_pkg::DEN_W+1];

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      quo_d  = req_i.num;
      rem_d  = '0;
      den_d  = req_i.den;
      cnt_d  = rcpw_pkg::DIV_CNT_W'(rcpw_pkg::NUM_W - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? trial[rcpw_pkg::DEN_W-1:0]
                 : {rem_q[rcpw_pkg::DEN_W-2:0], quo_q[rcpw_pkg::NUM_W-1]};
      quo_d = {quo_q[rcpw_pkg::NUM_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_i.start && busy_q))
    else $error("divider restarted while busy");

  a_done_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q) && !busy_q)
    else $error("divider done without a run");

endmodule

[hdl/rc_pulse_width_to_stick_value_core.sv]
// Top level: pin-edge timing, range check, serial mapping divide, result register.
//
//  channel | direction | handshake              | beat
//  --------+-----------+------------------------+------------------------------------
//  in      | input     | in_valid_i/in_stall_o  | chan_i, level_i, stamp_us_i
//  out     | output    | out_valid_o/out_stall_i| out_chan_o, stick_o, bad_width_o,
//          |           |                        | width_us_o
//  cfg     | input     | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
//  Rising edge: no result. Falling edge in range: capture, setup, the bit-serial
//  divider (one quotient bit per cycle), hand-off and finish. Falling edge out of
//  range or with equal calibration: capture, setup and finish, with no divide.
//  Reset clears rise times to zero and loads the calibration and dead band defaults.
//  A stalled result waits in the output register; the next beat is taken meanwhile,
//  and only its finish cycle waits for the register to drain.
module rc_pulse_width_to_stick_value_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [rcpw_pkg::CHAN_W-1:0]         chan_i,
  input  logic                                level_i,
  input  logic [rcpw_pkg::STAMP_W-1:0]        stamp_us_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [rcpw_pkg::CHAN_W-1:0]         out_chan_o,
  output logic signed [rcpw_pkg::STICK_W-1:0] stick_o,
  output logic                                bad_width_o,
  output logic [rcpw_pkg::STAMP_W-1:0]        width_us_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [rcpw_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [rcpw_pkg::CAL_W-1:0]          cfg_data_i
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PREP = 4'b0010,
    S_DIV  = 4'b0100,
    S_FIN  = 4'b1000
  } rcpw_state_e;

  rcpw_state_e state_q, state_d;

  logic [rcpw_pkg::STAMP_W-1:0] rise_q [rcpw_pkg::CHANNELS];
  logic [rcpw_pkg::CAL_W-1:0]   cal_q  [rcpw_pkg::CAL_COUNT];
  logic [rcpw_pkg::DEAD_W-1:0]  dead_q;

  logic [rcpw_pkg::CHAN_W-1:0]  chan_q;
  logic [rcpw_pkg::STAMP_W-1:0] width_q;
  logic                         bad_q;
  logic                         zero_q;
  logic                         neg_q;

  logic                         out_valid_q;
  logic [rcpw_pkg::CHAN_W-1:0]  out_chan_q;
  logic [rcpw_pkg::STICK_W-1:0] out_stick_q;
  logic                         out_bad_q;
  logic [rcpw_pkg::STAMP_W-1:0] out_width_q;

  logic in_fire, fin_fire, prep_go;

  logic [rcpw_pkg::CAL_W-1:0]    cal_sel;
  logic [rcpw_pkg::HALF_W-1:0]   cal_lo, cal_hi;
  logic                          in_range;
  logic [rcpw_pkg::HALF_W:0]     den_s, diff_s;
  logic [rcpw_pkg::HALF_W-1:0]   den_mag, diff_mag;
  logic [rcpw_pkg::NUM_W-1:0]    num_mag;

  logic [rcpw_pkg::NUM_W:0]      quo_s;
  logic [rcpw_pkg::NUM_W+1:0]    val_s;
  logic [rcpw_pkg::STICK_W-1:0]  sat_v, sat_mag, stick_d;
  logic [rcpw_pkg::STICK_W-1:0]  out_mag;

  rcpw_pkg::rcpw_div_req_t div_req;
  rcpw_pkg::rcpw_div_rsp_t div_rsp;

  rcpw_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign fin_fire   = (state_q == S_FIN) && (!out_valid_q || !out_stall_i);
  assign cfg_ready_o = 1'b1;

  // Setup: range check and the numerator and denominator magnitudes.
  assign cal_sel  = cal_q[chan_q];
  assign cal_lo   = cal_sel[rcpw_pkg::HALF_W-1:0];
  assign cal_hi   = cal_sel[rcpw_pkg::CAL_W-1:rcpw_pkg::HALF_W];
  assign in_range = (width_q > rcpw_pkg::WIDTH_LOW) && (width_q < rcpw_pkg::WIDTH_HIGH);
  assign den_s    = {1'b0, cal_hi} - {1'b0, cal_lo};
  assign diff_s   = {1'b0, width_q[rcpw_pkg::HALF_W-1:0]} - {1'b0, cal_lo};
  assign den_mag  = den_s[rcpw_pkg::HALF_W]
                  ? rcpw_pkg::HALF_W'(-den_s) : den_s[rcpw_pkg::HALF_W-1:0];
  assign diff_mag = diff_s[rcpw_pkg::HALF_W]
                  ? rcpw_pkg::HALF_W'(-diff_s) : diff_s[rcpw_pkg::HALF_W-1:0];
  assign num_mag  = rcpw_pkg::NUM_W'(diff_mag) * rcpw_pkg::OUT_SPAN;
  assign prep_go  = in_range && (den_s != '0);

  assign div_req.start = (state_q == S_PREP) && prep_go;
  assign div_req.num   = num_mag;
  assign div_req.den   = den_mag;

  // Finish: sign, offset, saturate, dead band, and zero for a bad width or equal calibration.
  assign quo_s = neg_q ? -{1'b0, div_rsp.quo} : {1'b0, div_rsp.quo};
  assign val_s = {quo_s[rcpw_pkg::NUM_W], quo_s} - rcpw_pkg::OUT_OFFSET;

  always_comb begin
    if ($signed(val_s) < -22'sd2048) begin
      sat_v = {1'b1, {(rcpw_pkg::STICK_W-1){1'b0}}};
    end else if ($signed(val_s) > 22'sd2047) begin
      sat_v = {1'b0, {(rcpw_pkg::STICK_W-1){1'b1}}};
    end else begin
      sat_v = val_s[rcpw_pkg::STICK_W-1:0];
    end
    sat_mag = sat_v[rcpw_pkg::STICK_W-1] ? -sat_v : sat_v;
    if (zero_q || bad_q || (sat_mag < rcpw_pkg::STICK_W'(dead_q))) begin
      stick_d = '0;
    end else begin
      stick_d = sat_v;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire && !level_i) begin
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        state_d = prep_go ? S_DIV : S_FIN;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (fin_fire) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      dead_q      <= rcpw_pkg::DEAD_RESET;
      for (int i = 0; i < rcpw_pkg::CHANNELS; i++) begin
        rise_q[i] <= '0;
      end
      for (int i = 0; i < rcpw_pkg::CAL_COUNT; i++) begin
        cal_q[i] <= rcpw_pkg::CAL_RESET;
      end
    end else begin
      state_q <= state_d;
      if (fin_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (in_fire && level_i) begin
        rise_q[chan_i] <= stamp_us_i;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == rcpw_pkg::CFG_IDX_DEAD_BAND) begin
          dead_q <= cfg_data_i[rcpw_pkg::DEAD_W-1:0];
        end else if (cfg_index_i < rcpw_pkg::CFG_IDX_CAL0 +
                     rcpw_pkg::CFG_IDX_W'(rcpw_pkg::CAL_COUNT)) begin
          cal_q[cfg_index_i[rcpw_pkg::CHAN_W-1:0]] <= cfg_data_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && !level_i) begin
      chan_q  <= chan_i;
      width_q <= stamp_us_i - rise_q[chan_i];
    end
    if (state_q == S_PREP) begin
      bad_q  <= !in_range;
      zero_q <= (den_s == '0);
      neg_q  <= diff_s[rcpw_pkg::HALF_W] ^ den_s[rcpw_pkg::HALF_W];
    end
    if (fin_fire) begin
      out_chan_q  <= chan_q;
      out_stick_q <= stick_d;
      out_bad_q   <= bad_q;
      out_width_q <= width_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_chan_o  = out_chan_q;
  assign stick_o     = out_stick_q;
  assign bad_width_o = out_bad_q;
  assign width_us_o  = out_width_q;

  assign out_mag = stick_o[rcpw_pkg::STICK_W-1] ? -out_stick_q : out_stick_q;

  a_bad_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_width_o |-> stick_o == '0)
    else $error("out-of-range width with nonzero stick");

  a_dead_band: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (stick_o != '0) |-> out_mag >= rcpw_pkg::STICK_W'(dead_q))
    else $error("stick inside dead band");

  a_fin_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN) && out_valid_q && out_stall_i |=> state_q == S_FIN)
    else $error("result overwrote a stalled beat");

  a_div_only_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == S_DIV)
    else $error("divider finished outside the divide phase");

endmodule
